>>> hdl/wegs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wegs_pkg;

    // fixed field widths
    localparam int HEIGHT_W    = 16;
    localparam int INDEX_W     = 12;
    localparam int COURANT_W   = 16;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COURANT_W-1:0] COURANT_RESET = 16'd4096;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP = 2'd2;

    // result kinds
    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_STEP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COURANT_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COURANT_Y = 1'b1;

    // bank select for the three rotating grid memories
    typedef logic [1:0] bank_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_SWEEP,
        ST_DRAIN,
        ST_BORDER,
        ST_FINISH,
        ST_EMIT
    } wegs_state_t;

endpackage

`default_nettype wire

>>> hdl/wave_equation_grid_step_core.sv
// add: the cell is read on acceptance and written back in ST_ADD, no result
// read: the cell is read on acceptance, then ST_EMIT loads the output register once it is free
// step: a sweep of the grid, one cell
//   per cycle through the stencil unit (set by the single read port of the current grid), then a border pass
// one item at a time; a finished result may wait in the output register while the next item runs
// reset clears control state, then a clear pass zeroes the current and previous grids (not ready)
`timescale 1ns / 1ps
`default_nettype none

module wave_equation_grid_step_core #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [wegs_pkg::REQ_W-1:0]           req_type,
    input  logic [wegs_pkg::INDEX_W-1:0]         cell_index,
    input  logic signed [wegs_pkg::HEIGHT_W-1:0] displacement,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 result_kind,
    output logic signed [wegs_pkg::HEIGHT_W-1:0] height_out,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wegs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wegs_pkg::COURANT_W-1:0]       cfg_data
);

    import wegs_pkg::*;

    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(GRID_ROWS);
    localparam int CW         = $clog2(GRID_COLS);
    localparam int WIN_LEN    = 2 * GRID_COLS;
    localparam int HW         = HEIGHT_W;
    localparam int DW         = HW + 2;
    localparam int PW         = DW + COURANT_W + 1;
    localparam int SW         = PW + 1;
    localparam int SPW        = SW - COURANT_W;
    localparam int TW         = ((SPW > DW) ? SPW : DW) + 1;
    localparam int AHW        = HW + 1;

    localparam logic signed [TW-1:0]  T_MAX      = TW'((2 ** (HW - 1)) - 1);
    localparam logic signed [TW-1:0]  T_MIN      = -T_MAX - TW'(1);
    localparam logic signed [AHW-1:0] A_MAX      = AHW'((2 ** (HW - 1)) - 1);
    localparam logic signed [AHW-1:0] A_MIN      = -A_MAX - AHW'(1);
    localparam logic signed [SW-1:0]  ROUND_HALF = SW'(2 ** (COURANT_W - 1));

    // control state
    wegs_state_t state_reg, state_next;
    bank_sel_t   role_reg, role_next;
    bank_sel_t   cur_sel, prev_sel, next_sel;

    logic [COURANT_W-1:0] courant_x_reg, courant_y_reg;

    logic [AW-1:0] sweep_pos_reg, sweep_pos_next;
    logic [RW-1:0] sweep_row_reg, sweep_row_next;
    logic [CW-1:0] sweep_col_reg, sweep_col_next;
    logic          sweep_last, sweep_interior;

    logic [RW-1:0] b_row_reg, b_row_next;
    logic [CW-1:0] b_col_reg, b_col_next;
    logic [AW-1:0] b_dst_reg, b_dst_next;
    logic [AW-1:0] b_src;
    logic          b_last;
    logic          b_valid_reg;
    logic [AW-1:0] b_wdst_reg;

    // latched request
    logic [REQ_W-1:0]       req_reg;
    logic [AW-1:0]          idx_reg;
    logic signed [HW-1:0]   disp_reg;
    logic                   in_range_reg;
    logic                   in_range;
    logic [AW-1:0]          in_addr;
    logic                   in_fire;

    // role-level memory requests
    logic                   cur_re, prev_re, next_re;
    logic [AW-1:0]          cur_raddr, prev_raddr, next_raddr;
    logic                   cur_we, prev_we, next_we;
    logic [AW-1:0]          cur_waddr, prev_waddr, next_waddr;
    logic signed [HW-1:0]   cur_wdata, prev_wdata, next_wdata;
    logic signed [HW-1:0]   cur_rdata, prev_rdata, next_rdata;

    // physical bank ports
    logic                   bank_we    [3];
    logic [AW-1:0]          bank_waddr [3];
    logic signed [HW-1:0]   bank_wdata [3];
    logic                   bank_re    [3];
    logic [AW-1:0]          bank_raddr [3];
    logic signed [HW-1:0]   bank_rdata [3];

    // stencil pipeline
    logic                   p1_valid_reg, p1_int_reg;
    logic [AW-1:0]          p1_addr_reg;
    logic signed [HW-1:0]   win_reg [1:WIN_LEN];
    logic signed [HW-1:0]   tap_n, tap_e, tap_c, tap_w, tap_s;
    logic signed [DW-1:0]   c_x2, dxx, dyy, base;

    logic                   s2_valid_reg;
    logic [AW-1:0]          s2_addr_reg;
    logic signed [DW-1:0]   s2_dxx_reg, s2_dyy_reg, s2_base_reg;
    logic signed [PW-1:0]   kx_ext, ky_ext, px, py;

    logic                   s3_valid_reg;
    logic [AW-1:0]          s3_addr_reg;
    logic signed [PW-1:0]   s3_px_reg, s3_py_reg;
    logic signed [DW-1:0]   s3_base_reg;
    logic signed [SW-1:0]   s3_sum;
    logic signed [SPW-1:0]  s3_spatial;
    logic signed [TW-1:0]   s3_total;
    logic signed [HW-1:0]   s3_sat;

    // add datapath
    logic signed [AHW-1:0]  add_cur, add_prev;
    logic signed [HW-1:0]   add_cur_sat, add_prev_sat;

    // output register
    logic                   out_valid_reg;
    logic                   result_kind_reg;
    logic signed [HW-1:0]   height_out_reg;
    logic                   emit_load;

    // handshakes
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign in_range  = (32'(cell_index) < 32'(CELL_COUNT));
    assign in_addr   = in_range ? AW'(cell_index) : '0;

    // role to bank mapping: cur, prev and next rotate after each step
    always_comb
    begin
        cur_sel = role_reg;
        unique case (role_reg)
            2'd0:
            begin
                prev_sel = 2'd1;
                next_sel = 2'd2;
            end
            2'd1:
            begin
                prev_sel = 2'd2;
                next_sel = 2'd0;
            end
            2'd2:
            begin
                prev_sel = 2'd0;
                next_sel = 2'd1;
            end
            default:
            begin
                prev_sel = 2'd1;
                next_sel = 2'd2;
            end
        endcase
    end

    // grid banks
    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        logic signed [HW-1:0] mem [CELL_COUNT];
        logic signed [HW-1:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[bank_waddr[b]] <= bank_wdata[b];
            end
            if (bank_re[b])
            begin
                rdata_reg <= mem[bank_raddr[b]];
            end
        end

        assign bank_rdata[b] = rdata_reg;
    end

    assign cur_rdata  = bank_rdata[cur_sel];
    assign prev_rdata = bank_rdata[prev_sel];
    assign next_rdata = bank_rdata[next_sel];

    // route role requests to physical banks
    always_comb
    begin
        for (int b = 0; b < 3; b++)
        begin
            if (cur_sel == 2'(b))
            begin
                bank_we[b]    = cur_we;
                bank_waddr[b] = cur_waddr;
                bank_wdata[b] = cur_wdata;
                bank_re[b]    = cur_re;
                bank_raddr[b] = cur_raddr;
            end
            else if (prev_sel == 2'(b))
            begin
                bank_we[b]    = prev_we;
                bank_waddr[b] = prev_waddr;
                bank_wdata[b] = prev_wdata;
                bank_re[b]    = prev_re;
                bank_raddr[b] = prev_raddr;
            end
            else
            begin
                bank_we[b]    = next_we;
                bank_waddr[b] = next_waddr;
                bank_wdata[b] = next_wdata;
                bank_re[b]    = next_re;
                bank_raddr[b] = next_raddr;
            end
        end
    end

    // sweep position decode
    assign sweep_last     = (sweep_pos_reg == AW'(CELL_COUNT - 1));
    assign sweep_interior = (sweep_row_reg >= RW'(2)) && (sweep_col_reg != '0)
                            && (sweep_col_reg != CW'(GRID_COLS - 1));

    // border pass: each border cell takes its clamped interior neighbor
    assign b_last = (b_row_reg == RW'(GRID_ROWS - 1)) && (b_col_reg == CW'(GRID_COLS - 1));
    assign b_src  = b_dst_reg
                    + ((b_row_reg == '0) ? AW'(GRID_COLS) : '0)
                    - ((b_row_reg == RW'(GRID_ROWS - 1)) ? AW'(GRID_COLS) : '0)
                    + ((b_col_reg == '0) ? AW'(1) : '0)
                    - ((b_col_reg == CW'(GRID_COLS - 1)) ? AW'(1) : '0);

    // add with saturation
    assign add_cur  = AHW'(cur_rdata) + AHW'(disp_reg);
    assign add_prev = AHW'(prev_rdata) + AHW'(disp_reg);
    assign add_cur_sat  = (add_cur > A_MAX) ? HW'(A_MAX) :
                          (add_cur < A_MIN) ? HW'(A_MIN) : add_cur[HW-1:0];
    assign add_prev_sat = (add_prev > A_MAX) ? HW'(A_MAX) :
                          (add_prev < A_MIN) ? HW'(A_MIN) : add_prev[HW-1:0];

    // stencil stage 1: window taps and second differences
    assign tap_n = cur_rdata;
    assign tap_e = win_reg[GRID_COLS - 1];
    assign tap_c = win_reg[GRID_COLS];
    assign tap_w = win_reg[GRID_COLS + 1];
    assign tap_s = win_reg[WIN_LEN];
    assign c_x2  = DW'(tap_c) <<< 1;
    assign dxx   = DW'(tap_e) + DW'(tap_w) - c_x2;
    assign dyy   = DW'(tap_n) + DW'(tap_s) - c_x2;
    assign base  = c_x2 - DW'(prev_rdata);

    // stencil stage 2: courant products
    assign kx_ext = PW'($signed({1'b0, courant_x_reg}));
    assign ky_ext = PW'($signed({1'b0, courant_y_reg}));
    assign px     = kx_ext * PW'(s2_dxx_reg);
    assign py     = ky_ext * PW'(s2_dyy_reg);

    // stencil stage 3: round, accumulate, saturate
    assign s3_sum     = SW'(s3_px_reg) + SW'(s3_py_reg) + ROUND_HALF;
    assign s3_spatial = s3_sum[SW-1:COURANT_W];
    assign s3_total   = TW'(s3_spatial) + TW'(s3_base_reg);
    assign s3_sat     = (s3_total > T_MAX) ? HW'(T_MAX) :
                        (s3_total < T_MIN) ? HW'(T_MIN) : s3_total[HW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority case (req_type)
                        REQ_ADD:  state_next = ST_ADD;
                        REQ_READ: state_next = ST_EMIT;
                        REQ_STEP: state_next = ST_SWEEP;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!(p1_valid_reg || s2_valid_reg || s3_valid_reg))
                begin
                    state_next = ST_BORDER;
                end
            end
            ST_BORDER:
            begin
                if (b_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // memory control per state
    always_comb
    begin
        cur_re     = 1'b0;
        cur_raddr  = '0;
        cur_we     = 1'b0;
        cur_waddr  = '0;
        cur_wdata  = '0;
        prev_re    = 1'b0;
        prev_raddr = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        next_re    = 1'b0;
        next_raddr = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_we     = 1'b1;
                cur_waddr  = sweep_pos_reg;
                prev_we    = 1'b1;
                prev_waddr = sweep_pos_reg;
            end
            ST_IDLE:
            begin
                cur_re     = in_fire;
                cur_raddr  = in_addr;
                prev_re    = in_fire;
                prev_raddr = in_addr;
            end
            ST_ADD:
            begin
                cur_we     = in_range_reg;
                cur_waddr  = idx_reg;
                cur_wdata  = add_cur_sat;
                prev_we    = in_range_reg;
                prev_waddr = idx_reg;
                prev_wdata = add_prev_sat;
            end
            ST_SWEEP:
            begin
                cur_re     = 1'b1;
                cur_raddr  = sweep_pos_reg;
                prev_re    = 1'b1;
                prev_raddr = sweep_pos_reg - AW'(GRID_COLS);
            end
            ST_BORDER:
            begin
                next_re    = 1'b1;
                next_raddr = b_src;
            end
            default:
            begin
                cur_re = 1'b0;
            end
        endcase
    end

    // the next grid is written by the stencil pipeline or the border pass
    assign next_we    = s3_valid_reg || b_valid_reg;
    assign next_waddr = s3_valid_reg ? s3_addr_reg : b_wdst_reg;
    assign next_wdata = s3_valid_reg ? s3_sat : next_rdata;

    // counters and role
    always_comb
    begin
        sweep_pos_next = '0;
        sweep_row_next = '0;
        sweep_col_next = '0;
        b_row_next     = '0;
        b_col_next     = '0;
        b_dst_next     = '0;
        role_next      = role_reg;

        if ((state_reg == ST_CLEAR || state_reg == ST_SWEEP) && !sweep_last)
        begin
            sweep_pos_next = sweep_pos_reg + AW'(1);
            if (sweep_col_reg == CW'(GRID_COLS - 1))
            begin
                sweep_row_next = sweep_row_reg + RW'(1);
            end
            else
            begin
                sweep_row_next = sweep_row_reg;
                sweep_col_next = sweep_col_reg + CW'(1);
            end
        end

        if (state_reg == ST_BORDER && !b_last)
        begin
            priority if (b_col_reg == CW'(GRID_COLS - 1))
            begin
                b_row_next = b_row_reg + RW'(1);
                b_dst_next = b_dst_reg + AW'(1);
            end
            else if (b_row_reg == '0 || b_row_reg == RW'(GRID_ROWS - 1))
            begin
                b_row_next = b_row_reg;
                b_col_next = b_col_reg + CW'(1);
                b_dst_next = b_dst_reg + AW'(1);
            end
            else
            begin
                b_row_next = b_row_reg;
                b_col_next = CW'(GRID_COLS - 1);
                b_dst_next = b_dst_reg + AW'(GRID_COLS - 1);
            end
        end

        if (state_reg == ST_FINISH)
        begin
            role_next = next_sel;
        end
    end

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            role_reg      <= 2'd0;
            sweep_pos_reg <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            b_row_reg     <= '0;
            b_col_reg     <= '0;
            b_dst_reg     <= '0;
            b_valid_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            courant_x_reg <= COURANT_RESET;
            courant_y_reg <= COURANT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            role_reg      <= role_next;
            sweep_pos_reg <= sweep_pos_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            b_row_reg     <= b_row_next;
            b_col_reg     <= b_col_next;
            b_dst_reg     <= b_dst_next;
            b_valid_reg   <= (state_reg == ST_BORDER);
            p1_valid_reg  <= (state_reg == ST_SWEEP);
            s2_valid_reg  <= p1_valid_reg && p1_int_reg;
            s3_valid_reg  <= s2_valid_reg;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COURANT_X: courant_x_reg <= cfg_data;
                    REG_COURANT_Y: courant_y_reg <= cfg_data;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg      <= req_type;
            idx_reg      <= in_addr;
            disp_reg     <= displacement;
            in_range_reg <= in_range;
        end

        b_wdst_reg  <= b_dst_reg;
        p1_int_reg  <= sweep_interior;
        p1_addr_reg <= sweep_pos_reg - AW'(GRID_COLS);

        // window of the current grid in raster order
        if (p1_valid_reg)
        begin
            win_reg[1] <= cur_rdata;
            for (int k = 2; k <= WIN_LEN; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
        end

        s2_addr_reg <= p1_addr_reg;
        s2_dxx_reg  <= dxx;
        s2_dyy_reg  <= dyy;
        s2_base_reg <= base;

        s3_addr_reg <= s2_addr_reg;
        s3_px_reg   <= px;
        s3_py_reg   <= py;
        s3_base_reg <= s2_base_reg;

        if (emit_load)
        begin
            result_kind_reg <= (req_reg == REQ_STEP) ? RESULT_STEP : RESULT_READ;
            height_out_reg  <= (req_reg == REQ_STEP || !in_range_reg) ? '0 : cur_rdata;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign height_out  = height_out_reg;

`ifndef SYNTHESIS
    // stencil writes and border writes share the next-grid port
    a_next_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s3_valid_reg && b_valid_reg))
        else $error("stencil and border writes collide on next grid");

    // border pass reads only after the stencil pipeline is empty
    a_border_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BORDER) |-> !(p1_valid_reg || s2_valid_reg || s3_valid_reg))
        else $error("border pass started with stencil pipeline busy");

    // grid roles rotate at the end of every step
    a_role_rotates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (role_reg != $past(role_reg)))
        else $error("grid roles did not rotate after step");

    // role pointer stays within the three banks
    a_role_range: assert property (@(posedge clk) disable iff (!rst_n)
        role_reg != 2'd3)
        else $error("grid role pointer out of range");
`endif

endmodule

`default_nettype wire
